>>> src/lle_pkg.sv
// ----------------------------------------------------------------------------
// lle_pkg
// Shared constants, command codes and interface structs of the ladder logic
// executor core.
// ----------------------------------------------------------------------------
package lle_pkg;

	// Sizes of the variable memory and the two stacks
	localparam int MEM_BYTES  = 256;
	localparam int COND_DEPTH = 16;
	localparam int OR_DEPTH   = 16;

	// Address widths: instruction operand, extended timer block address,
	// memory index
	localparam int ADDR_W  = 8;
	localparam int XADDR_W = ADDR_W + 1;
	localparam int MEM_AW  = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	// Stack index and pointer widths (the pointer can hold the depth itself)
	localparam int CIDX_W = $clog2(COND_DEPTH);
	localparam int CPTR_W = $clog2(COND_DEPTH + 1);
	localparam int OIDX_W = $clog2(OR_DEPTH);
	localparam int OPTR_W = $clog2(OR_DEPTH + 1);

	// Byte offsets inside a timer block
	localparam logic [XADDR_W-1:0] TMR_PRE_HI = XADDR_W'(2);
	localparam logic [XADDR_W-1:0] TMR_PRE_LO = XADDR_W'(3);
	localparam logic [XADDR_W-1:0] TMR_ACC_HI = XADDR_W'(4);
	localparam logic [XADDR_W-1:0] TMR_ACC_LO = XADDR_W'(5);

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CR_OVER   = 3'd1;
	localparam logic [2:0] ST_CR_UNDER  = 3'd2;
	localparam logic [2:0] ST_OR_OVER   = 3'd3;
	localparam logic [2:0] ST_OR_UNDER  = 3'd4;

	// Instruction and host command codes
	typedef enum logic [3:0] {
		CMD_SCAN_START = 4'd0,
		CMD_CLEAR      = 4'd1,
		CMD_PUSH_CR    = 4'd2,
		CMD_POP_CR     = 4'd3,
		CMD_PUSH_OR    = 4'd4,
		CMD_POP_OR     = 4'd5,
		CMD_XIO        = 4'd6,
		CMD_XIC        = 4'd7,
		CMD_OTE        = 4'd8,
		CMD_OTL        = 4'd9,
		CMD_OTU        = 4'd10,
		CMD_TMR        = 4'd11,
		CMD_SCAN_END   = 4'd12,
		CMD_READ       = 4'd13,
		CMD_WRITE      = 4'd14,
		CMD_NOP        = 4'd15
	} cmd_t;

	// Read request to the variable store: two byte ports
	typedef struct packed {
		logic               re;
		logic [XADDR_W-1:0] addr_a;
		logic [XADDR_W-1:0] addr_b;
	} rd_req_t;

	// Write request to the variable store: one byte port
	typedef struct packed {
		logic               we;
		logic [XADDR_W-1:0] addr;
		logic [7:0]         data;
	} wr_req_t;

	// One result transaction
	typedef struct packed {
		logic        rung;
		logic [2:0]  status;
		logic        aborted;
		logic [7:0]  read_data;
		logic [31:0] scan_count;
	} result_t;

endpackage

>>> src/lle_var_store.sv
// ----------------------------------------------------------------------------
// lle_var_store
// Byte-wide variable memory with two registered read ports and one write
// port. Per-entry valid bits make never-written bytes read as zero, reads
// outside the memory return zero, writes outside it are dropped, and a write
// to the address being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module lle_var_store import lle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd_req,
	input  wr_req_t wr_req,
	output logic [7:0] rd_a,
	output logic [7:0] rd_b
);

	logic [7:0]           mem [MEM_BYTES];
	logic [MEM_BYTES-1:0] vld_q;

	logic              w_inr;
	logic              a_inr;
	logic              b_inr;
	logic [MEM_AW-1:0] w_idx;
	logic [MEM_AW-1:0] a_idx;
	logic [MEM_AW-1:0] b_idx;
	logic              hit_a;
	logic              hit_b;

	logic [7:0] raw_a_q;
	logic [7:0] raw_b_q;
	logic       ok_a_q;
	logic       ok_b_q;
	logic       byp_a_q;
	logic       byp_b_q;
	logic [7:0] bdata_q;

	// Decode addresses and range
	assign w_inr = wr_req.addr   < XADDR_W'(MEM_BYTES);
	assign a_inr = rd_req.addr_a < XADDR_W'(MEM_BYTES);
	assign b_inr = rd_req.addr_b < XADDR_W'(MEM_BYTES);
	assign w_idx = wr_req.addr[MEM_AW-1:0];
	assign a_idx = rd_req.addr_a[MEM_AW-1:0];
	assign b_idx = rd_req.addr_b[MEM_AW-1:0];
	assign hit_a = wr_req.we && w_inr && (wr_req.addr == rd_req.addr_a);
	assign hit_b = wr_req.we && w_inr && (wr_req.addr == rd_req.addr_b);

	// Write port
	always_ff @(posedge clk) begin
		if (wr_req.we && w_inr) begin
			mem[w_idx] <= wr_req.data;
		end
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_req.we && w_inr) begin
			vld_q[w_idx] <= 1'b1;
		end
	end

	// Read ports with registered data
	always_ff @(posedge clk) begin
		if (rd_req.re) begin
			raw_a_q <= mem[a_idx];
			raw_b_q <= mem[b_idx];
			ok_a_q  <= a_inr && vld_q[a_idx];
			ok_b_q  <= b_inr && vld_q[b_idx];
			byp_a_q <= hit_a;
			byp_b_q <= hit_b;
			bdata_q <= wr_req.data;
		end
	end

	// Forward, then mask unwritten and out-of-range bytes
	assign rd_a = byp_a_q ? bdata_q : (ok_a_q ? raw_a_q : 8'h00);
	assign rd_b = byp_b_q ? bdata_q : (ok_b_q ? raw_b_q : 8'h00);

endmodule

>>> src/lle_exec.sv
// ----------------------------------------------------------------------------
// lle_exec
// Instruction stage of the ladder logic executor: holds one transaction,
// issues variable reads, updates the rung, stacks and scan state, and
// sequences the timer instruction through four phases.
// ----------------------------------------------------------------------------
module lle_exec import lle_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_acc,
	input  logic [3:0]    cmd,
	input  logic [7:0]    addr,
	input  logic [7:0]    wdata,
	input  logic [15:0]   dt,
	input  logic          out_free,
	output logic          busy,
	output logic          done,
	output result_t       res,
	output rd_req_t       rd_req,
	output wr_req_t       wr_req,
	input  logic [7:0]    rd_a,
	input  logic [7:0]    rd_b
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_ACC,
		PH_HI,
		PH_LO
	} phase_t;

	phase_t phase_q;
	logic   valid_s1;

	cmd_t        cmd_s1;
	logic [7:0]  addr_s1;
	logic [7:0]  wdata_s1;
	logic [15:0] dt_s1;

	logic              rung_q;
	logic [CPTR_W-1:0] cptr_q;
	logic [OPTR_W-1:0] optr_q;
	logic              abort_q;
	logic [2:0]        fault_q;
	logic [31:0]       scans_q;
	logic              cstk_q [COND_DEPTH];
	logic              ostk_q [OR_DEPTH];
	logic [15:0]       pre_q;
	logic [15:0]       acc_q;

	logic [XADDR_W-1:0] addr_x;
	logic [XADDR_W-1:0] in_addr_x;
	logic               tmr_run;
	logic               last;
	logic               pre_ok;
	logic               acc_ok;
	logic [15:0]        acc_w;
	logic [15:0]        sum;
	logic [15:0]        clamp;
	logic               tmr_rung;
	logic [15:0]        acc_new;

	logic [CPTR_W-1:0] cptr_inc;
	logic [CPTR_W-1:0] cptr_dec;
	logic [OPTR_W-1:0] optr_inc;
	logic [OPTR_W-1:0] optr_dec;

	logic              rung_n;
	logic [CPTR_W-1:0] cptr_n;
	logic [OPTR_W-1:0] optr_n;
	logic              abort_n;
	logic [2:0]        fault_n;
	logic [31:0]       scans_n;
	logic [7:0]        rdata_n;
	logic              c_wr;
	logic              o_wr;

	// Stage control
	assign addr_x    = {1'b0, addr_s1};
	assign in_addr_x = {1'b0, addr};
	assign tmr_run   = (cmd_s1 == CMD_TMR) && !abort_q;
	assign last      = !tmr_run || (phase_q == PH_LO);
	assign done      = valid_s1 && last && out_free;
	assign busy      = valid_s1;

	// Timer block bounds: a word reads as zero unless both bytes exist
	assign pre_ok = (addr_x + TMR_PRE_LO) < XADDR_W'(MEM_BYTES);
	assign acc_ok = (addr_x + TMR_ACC_LO) < XADDR_W'(MEM_BYTES);

	// Timer accumulate and clamp
	assign acc_w    = acc_ok ? {rd_a, rd_b} : 16'h0000;
	assign sum      = acc_w + dt_s1;
	assign clamp    = (sum > pre_q) ? pre_q : sum;
	assign tmr_rung = rung_q && (clamp >= pre_q);
	assign acc_new  = rung_q ? clamp : 16'h0000;

	// Stack pointer arithmetic
	assign cptr_inc = cptr_q + 1'b1;
	assign cptr_dec = cptr_q - 1'b1;
	assign optr_inc = optr_q + 1'b1;
	assign optr_dec = optr_q - 1'b1;

	// Read requests: operand byte or preset word on accept, accumulator next
	always_comb begin
		rd_req.re = in_acc || (valid_s1 && tmr_run && (phase_q == PH_FIRST));
		if (in_acc) begin
			rd_req.addr_a = (cmd_t'(cmd) == CMD_TMR) ? (in_addr_x + TMR_PRE_HI) : in_addr_x;
			rd_req.addr_b = in_addr_x + TMR_PRE_LO;
		end else begin
			rd_req.addr_a = addr_x + TMR_ACC_HI;
			rd_req.addr_b = addr_x + TMR_ACC_LO;
		end
	end

	// Next architectural state of a finishing transaction
	always_comb begin
		rung_n  = rung_q;
		cptr_n  = cptr_q;
		optr_n  = optr_q;
		abort_n = abort_q;
		fault_n = fault_q;
		scans_n = scans_q;
		rdata_n = 8'h00;
		c_wr    = 1'b0;
		o_wr    = 1'b0;
		case (cmd_s1)
			CMD_SCAN_START: begin
				cptr_n  = '0;
				optr_n  = '0;
				rung_n  = 1'b1;
				abort_n = 1'b0;
				fault_n = ST_OK;
			end
			CMD_SCAN_END: begin
				if (!abort_q) begin
					scans_n = scans_q + 32'd1;
				end
			end
			CMD_READ: begin
				rdata_n = rd_a;
			end
			CMD_CLEAR: begin
				if (!abort_q) begin
					rung_n = 1'b1;
				end
			end
			CMD_PUSH_CR: begin
				if (!abort_q) begin
					c_wr   = cptr_q < CPTR_W'(COND_DEPTH);
					cptr_n = cptr_inc;
					if (cptr_inc >= CPTR_W'(COND_DEPTH)) begin
						abort_n = 1'b1;
						fault_n = ST_CR_OVER;
					end
				end
			end
			CMD_POP_CR: begin
				if (!abort_q) begin
					if (cptr_q == '0 || cptr_q > CPTR_W'(COND_DEPTH)) begin
						abort_n = 1'b1;
						fault_n = ST_CR_UNDER;
					end else begin
						cptr_n = cptr_dec;
						rung_n = cstk_q[cptr_dec[CIDX_W-1:0]];
					end
				end
			end
			CMD_PUSH_OR: begin
				if (!abort_q) begin
					o_wr   = optr_q < OPTR_W'(OR_DEPTH);
					optr_n = optr_inc;
					if (optr_inc >= OPTR_W'(OR_DEPTH)) begin
						abort_n = 1'b1;
						fault_n = ST_OR_OVER;
					end
				end
			end
			CMD_POP_OR: begin
				if (!abort_q) begin
					if (optr_q == '0 || optr_q > OPTR_W'(OR_DEPTH)) begin
						abort_n = 1'b1;
						fault_n = ST_OR_UNDER;
					end else begin
						optr_n = optr_dec;
						rung_n = rung_q | ostk_q[optr_dec[OIDX_W-1:0]];
					end
				end
			end
			CMD_XIO: begin
				if (!abort_q) begin
					rung_n = rung_q && (rd_a == 8'h00);
				end
			end
			CMD_XIC: begin
				if (!abort_q) begin
					rung_n = rung_q && rd_a[0];
				end
			end
			default: begin
			end
		endcase
	end

	// Variable writes: output coils, host write and the timer write-back
	always_comb begin
		wr_req.we   = 1'b0;
		wr_req.addr = addr_x;
		wr_req.data = wdata_s1;
		if (valid_s1 && tmr_run) begin
			case (phase_q)
				PH_ACC: begin
					wr_req.we   = 1'b1;
					wr_req.data = {7'b0, tmr_rung};
				end
				PH_HI: begin
					wr_req.we   = acc_ok;
					wr_req.addr = addr_x + TMR_ACC_HI;
					wr_req.data = acc_q[15:8];
				end
				PH_LO: begin
					wr_req.we   = acc_ok && done;
					wr_req.addr = addr_x + TMR_ACC_LO;
					wr_req.data = acc_q[7:0];
				end
				default: begin
				end
			endcase
		end else if (done) begin
			case (cmd_s1)
				CMD_WRITE: begin
					wr_req.we = 1'b1;
				end
				CMD_OTE: begin
					wr_req.we   = !abort_q;
					wr_req.data = {7'b0, rung_q};
				end
				CMD_OTL: begin
					wr_req.we   = !abort_q && rung_q;
					wr_req.data = 8'h01;
				end
				CMD_OTU: begin
					wr_req.we   = !abort_q && rung_q;
					wr_req.data = 8'h00;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the transaction and step the timer phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_FIRST;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			phase_q  <= PH_FIRST;
		end else if (done) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_FIRST;
		end else if (valid_s1 && tmr_run) begin
			case (phase_q)
				PH_FIRST: phase_q <= PH_ACC;
				PH_ACC:   phase_q <= PH_HI;
				PH_HI:    phase_q <= PH_LO;
				default:  phase_q <= PH_LO;
			endcase
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd_t'(cmd);
			addr_s1  <= addr;
			wdata_s1 <= wdata;
			dt_s1    <= dt;
		end
	end

	// Latch timer preset and new accumulator
	always_ff @(posedge clk) begin
		if (valid_s1 && tmr_run && (phase_q == PH_FIRST)) begin
			pre_q <= pre_ok ? {rd_a, rd_b} : 16'h0000;
		end
		if (valid_s1 && tmr_run && (phase_q == PH_ACC)) begin
			acc_q <= acc_new;
		end
	end

	// Commit rung, pointers and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rung_q  <= 1'b1;
			cptr_q  <= '0;
			optr_q  <= '0;
			abort_q <= 1'b0;
			fault_q <= ST_OK;
			scans_q <= '0;
		end else if (valid_s1 && tmr_run && (phase_q == PH_ACC)) begin
			rung_q <= tmr_rung;
		end else if (done) begin
			rung_q  <= rung_n;
			cptr_q  <= cptr_n;
			optr_q  <= optr_n;
			abort_q <= abort_n;
			fault_q <= fault_n;
			scans_q <= scans_n;
		end
	end

	// Push onto the condition and OR stacks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COND_DEPTH; i++) begin
				cstk_q[i] <= 1'b0;
			end
			for (int j = 0; j < OR_DEPTH; j++) begin
				ostk_q[j] <= 1'b0;
			end
		end else if (done) begin
			if (c_wr) begin
				cstk_q[cptr_q[CIDX_W-1:0]] <= rung_q;
			end
			if (o_wr) begin
				ostk_q[optr_q[OIDX_W-1:0]] <= rung_q;
			end
		end
	end

	// Result of the finishing transaction
	assign res.rung       = rung_n;
	assign res.status     = fault_n;
	assign res.aborted    = abort_n;
	assign res.read_data  = rdata_n;
	assign res.scan_count = scans_n;

endmodule

>>> src/ladder_logic_executor_core.sv
// ----------------------------------------------------------------------------
// ladder_logic_executor_core
// Ladder logic instruction executor over a byte-wide variable memory.
// ----------------------------------------------------------------------------
// Each input transaction carries one instruction or host command and yields
// exactly one result transaction with the rung condition, status, abort flag,
// read byte and completed scan count. Every command but the timer finishes once
// the result register is free, so such transactions can be accepted on
// consecutive cycles; a timer instruction steps through four phases, as the
// single write port of the variable memory writes back the rung byte and the
// two accumulator bytes one per cycle barring output stalls, after the preset
// and the accumulator are read through the two read ports. The variable memory
// reads zero after reset without a clearing pass. A result register decouples
// the output side, so a new transaction is taken while a result is pending.
// ----------------------------------------------------------------------------
module ladder_logic_executor_core import lle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [7:0]  addr,
	input  logic [7:0]  wdata,
	input  logic [15:0] dt,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rung,
	output logic [2:0]  status,
	output logic        aborted,
	output logic [7:0]  read_data,
	output logic [31:0] scan_count
);

	logic    in_acc;
	logic    out_free;
	logic    busy;
	logic    done;
	result_t res;
	rd_req_t rd_req;
	wr_req_t wr_req;
	logic [7:0] rd_a;
	logic [7:0] rd_b;

	logic    out_valid_q;
	result_t res_q;

	// Handshake: the stage frees up when its transaction finishes
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !busy || done;
	assign in_acc   = in_valid && in_ready;

	lle_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.cmd      (cmd),
		.addr     (addr),
		.wdata    (wdata),
		.dt       (dt),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.res      (res),
		.rd_req   (rd_req),
		.wr_req   (wr_req),
		.rd_a     (rd_a),
		.rd_b     (rd_b)
	);

	lle_var_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (rd_req),
		.wr_req (wr_req),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	// Hold the result until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign rung       = res_q.rung;
	assign status     = res_q.status;
	assign aborted    = res_q.aborted;
	assign read_data  = res_q.read_data;
	assign scan_count = res_q.scan_count;

endmodule

>>> tb/ladder_exec_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ladder_exec_monitor
// Watches both channels of the ladder logic executor core, computes the
// outcome of every accepted instruction on a private copy of the variable
// memory, stacks and scan state, and compares each result transaction with
// the oldest outcome still due.
// ----------------------------------------------------------------------------
module ladder_exec_monitor import lle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [7:0]  addr,
	input  logic [7:0]  wdata,
	input  logic [15:0] dt,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        rung,
	input  logic [2:0]  status,
	input  logic        aborted,
	input  logic [7:0]  read_data,
	input  logic [31:0] scan_count,
	output int          mismatches,
	output int          outcomes_due
);

	// Shadow of the executor state
	logic [7:0]  shadow_mem [MEM_BYTES];
	logic        cur_rung;
	logic        cond_shadow [COND_DEPTH];
	logic        or_shadow [OR_DEPTH];
	int          cr_ptr;
	int          or_ptr;
	logic        scan_halted;
	logic [2:0]  halt_code;
	logic [31:0] scans_completed;

	result_t     ladder_outcomes [$];

	function automatic logic [7:0] peek_byte(input int a);
		return (a < MEM_BYTES) ? shadow_mem[a] : 8'h00;
	endfunction

	function automatic int peek_word(input int a);
		if (a + 1 >= MEM_BYTES)
			return 0;
		return {shadow_mem[a], shadow_mem[a + 1]};
	endfunction

	function automatic void poke_byte(input int a, input logic [7:0] v);
		if (a < MEM_BYTES)
			shadow_mem[a] = v;
	endfunction

	function automatic void poke_word(input int a, input int v);
		if (a + 1 < MEM_BYTES) begin
			shadow_mem[a]     = v[15:8];
			shadow_mem[a + 1] = v[7:0];
		end
	endfunction

	function automatic void halt_scan(input logic [2:0] code);
		scan_halted = 1'b1;
		halt_code   = code;
	endfunction

	function automatic void clear_shadow();
		foreach (shadow_mem[i])
			shadow_mem[i] = 8'h00;
		foreach (cond_shadow[i])
			cond_shadow[i] = 1'b0;
		foreach (or_shadow[i])
			or_shadow[i] = 1'b0;
		cur_rung        = 1'b1;
		cr_ptr          = 0;
		or_ptr          = 0;
		scan_halted     = 1'b0;
		halt_code       = ST_OK;
		scans_completed = '0;
	endfunction

	// Execute one instruction on the shadow state and return its outcome
	function automatic result_t execute_instruction(input cmd_t op, input int a,
			input logic [7:0] wd, input int ticks);
		result_t res;
		int      preset;
		int      accum;
		logic [7:0] rd;
		logic [7:0] vb;

		rd = 8'h00;
		if (op == CMD_SCAN_START) begin
			cr_ptr      = 0;
			or_ptr      = 0;
			cur_rung    = 1'b1;
			scan_halted = 1'b0;
			halt_code   = ST_OK;
		end else if (op == CMD_SCAN_END) begin
			if (!scan_halted)
				scans_completed++;
		end else if (op == CMD_READ) begin
			rd = peek_byte(a);
		end else if (op == CMD_WRITE) begin
			poke_byte(a, wd);
		end else if (op != CMD_NOP && !scan_halted) begin
			case (op)
				CMD_CLEAR: cur_rung = 1'b1;
				CMD_PUSH_CR: begin
					if (cr_ptr < COND_DEPTH)
						cond_shadow[cr_ptr] = cur_rung;
					cr_ptr++;
					if (cr_ptr >= COND_DEPTH)
						halt_scan(ST_CR_OVER);
				end
				CMD_POP_CR: begin
					if (cr_ptr == 0 || cr_ptr > COND_DEPTH) begin
						halt_scan(ST_CR_UNDER);
					end else begin
						cr_ptr--;
						cur_rung = cond_shadow[cr_ptr];
					end
				end
				CMD_PUSH_OR: begin
					if (or_ptr < OR_DEPTH)
						or_shadow[or_ptr] = cur_rung;
					or_ptr++;
					if (or_ptr >= OR_DEPTH)
						halt_scan(ST_OR_OVER);
				end
				CMD_POP_OR: begin
					if (or_ptr == 0 || or_ptr > OR_DEPTH) begin
						halt_scan(ST_OR_UNDER);
					end else begin
						or_ptr--;
						cur_rung = cur_rung | or_shadow[or_ptr];
					end
				end
				CMD_XIO: cur_rung = cur_rung & (peek_byte(a) == 8'h00);
				CMD_XIC: begin
					vb       = peek_byte(a);
					cur_rung = cur_rung & vb[0];
				end
				CMD_OTE: poke_byte(a, {7'b0, cur_rung});
				CMD_OTL: if (cur_rung) poke_byte(a, 8'h01);
				CMD_OTU: if (cur_rung) poke_byte(a, 8'h00);
				default: begin
					// on-delay timer: preset at a+2, accumulator at a+4, big-endian
					preset = peek_word(a + 2);
					accum  = peek_word(a + 4);
					if (cur_rung) begin
						accum = (accum + ticks) & 16'hffff;
						if (accum > preset)
							accum = preset;
						cur_rung = (accum >= preset);
					end else begin
						accum = 0;
					end
					poke_byte(a, {7'b0, cur_rung});
					poke_word(a + 4, accum);
				end
			endcase
		end

		res.rung       = cur_rung;
		res.status     = halt_code;
		res.aborted    = scan_halted;
		res.read_data  = rd;
		res.scan_count = scans_completed;
		return res;
	endfunction

	// Predict on every input transaction, compare on every result transaction
	always @(posedge clk or negedge arst_n) begin
		result_t due;

		if (!arst_n) begin
			clear_shadow();
			ladder_outcomes.delete();
			mismatches   = 0;
			outcomes_due = 0;
		end else begin
			if (in_valid && in_ready)
				ladder_outcomes.push_back(execute_instruction(cmd_t'(cmd), int'(addr),
					wdata, int'(dt)));
			if (out_valid && out_ready) begin
				if (ladder_outcomes.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					mismatches++;
				end else begin
					due = ladder_outcomes.pop_front();
					if (rung !== due.rung) begin
						$error("rung: expected %0d, got %0d", due.rung, rung);
						mismatches++;
					end
					if (status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, status);
						mismatches++;
					end
					if (aborted !== due.aborted) begin
						$error("aborted: expected %0d, got %0d", due.aborted, aborted);
						mismatches++;
					end
					if (read_data !== due.read_data) begin
						$error("read_data: expected 0x%02h, got 0x%02h", due.read_data,
							read_data);
						mismatches++;
					end
					if (scan_count !== due.scan_count) begin
						$error("scan_count: expected %0d, got %0d", due.scan_count,
							scan_count);
						mismatches++;
					end
				end
			end
			outcomes_due = ladder_outcomes.size();
		end
	end

endmodule

>>> tb/ladder_logic_executor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ladder_logic_executor_core_test
// Drives instruction streams into the ladder logic executor core and reports
// the verdict. A short directed sequence hits stack underflow faults, aborted
// scans, timer clamping and out-of-range timer blocks; then randomized scans
// run under four flow-control phases while the monitor checks every result.
// ----------------------------------------------------------------------------
module ladder_logic_executor_core_test;
	import lle_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int ITEMS_PER_PASS = 190;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [3:0]  cmd       = CMD_NOP;
	logic [7:0]  addr      = 8'h00;
	logic [7:0]  wdata     = 8'h00;
	logic [15:0] dt        = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        rung;
	logic [2:0]  status;
	logic        aborted;
	logic [7:0]  read_data;
	logic [31:0] scan_count;

	int mismatches;
	int outcomes_due;
	int cycles         = 0;
	int sent           = 0;
	int send_idle_pct  = 0;
	int sink_stall_pct = 0;

	ladder_logic_executor_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.addr       (addr),
		.wdata      (wdata),
		.dt         (dt),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rung       (rung),
		.status     (status),
		.aborted    (aborted),
		.read_data  (read_data),
		.scan_count (scan_count)
	);

	ladder_exec_monitor monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.addr         (addr),
		.wdata        (wdata),
		.dt           (dt),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rung         (rung),
		.status       (status),
		.aborted      (aborted),
		.read_data    (read_data),
		.scan_count   (scan_count),
		.mismatches   (mismatches),
		.outcomes_due (outcomes_due)
	);

	always #5 clk = ~clk;

	// Stall the result channel at random
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= sink_stall_pct);

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** ladder_logic_executor_core: FAILED **");
			$finish;
		end
	end

	// Present one transaction and hold it until accepted
	task automatic issue(input cmd_t op, input logic [7:0] a,
			input logic [7:0] wd = 8'h00, input logic [15:0] ticks = 16'h0000);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		addr     <= a;
		wdata    <= wd;
		dt       <= ticks;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// Favor a few low and high bytes so reads hit earlier writes
	function automatic logic [7:0] pick_var();
		int r;

		r = $urandom_range(99);
		if (r < 60)
			return 8'($urandom_range(15));
		if (r < 80)
			return 8'($urandom_range(255, 240));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_ticks();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3: return 16'($urandom_range(300));
			default: return 16'($urandom);
		endcase
	endfunction

	// One well-formed scan with random content, sometimes driving a stack deep
	task automatic run_scan();
		int cr_depth;
		int or_depth;
		int body;
		int r;

		cr_depth = 0;
		or_depth = 0;
		issue(CMD_SCAN_START, 8'($urandom));
		if ($urandom_range(99) < 8) begin
			r = $urandom_range(1);
			repeat ($urandom_range(17, 14))
				issue(r ? CMD_PUSH_CR : CMD_PUSH_OR, 8'($urandom));
		end
		body = $urandom_range(14, 2);
		repeat (body) begin
			r = $urandom_range(99);
			if (r < 8) begin
				issue(CMD_PUSH_CR, pick_var());
				cr_depth++;
			end else if (r < 15) begin
				if (cr_depth > 0 || $urandom_range(9) == 0) begin
					issue(CMD_POP_CR, pick_var());
					if (cr_depth > 0)
						cr_depth--;
				end
			end else if (r < 22) begin
				issue(CMD_PUSH_OR, pick_var());
				or_depth++;
			end else if (r < 29) begin
				if (or_depth > 0 || $urandom_range(9) == 0) begin
					issue(CMD_POP_OR, pick_var());
					if (or_depth > 0)
						or_depth--;
				end
			end else if (r < 44) issue(CMD_XIC, pick_var());
			else if (r < 54) issue(CMD_XIO, pick_var());
			else if (r < 63) issue(CMD_OTE, pick_var());
			else if (r < 70) issue(CMD_OTL, pick_var());
			else if (r < 77) issue(CMD_OTU, pick_var());
			else if (r < 90) issue(CMD_TMR, pick_var(), 8'($urandom), pick_ticks());
			else if (r < 95) issue(CMD_CLEAR, pick_var());
			else issue(CMD_NOP, 8'($urandom));
		end
		// unwind what is left most of the time
		if ($urandom_range(3) != 0) begin
			repeat (cr_depth) issue(CMD_POP_CR, pick_var());
			repeat (or_depth) issue(CMD_POP_OR, pick_var());
		end
		issue(CMD_SCAN_END, 8'($urandom));
	endtask

	initial begin
		int pass_end;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: host access, timer clamp and reset, stack underflow faults, aborted scan
		issue(CMD_READ, 8'h00);
		issue(CMD_WRITE, 8'hff, 8'hff);
		issue(CMD_READ, 8'hff);
		issue(CMD_WRITE, 8'h02, 8'h01);
		issue(CMD_SCAN_START, 8'h00);
		issue(CMD_XIC, 8'hff);
		issue(CMD_TMR, 8'h00, 8'h00, 16'hffff);
		issue(CMD_XIO, 8'hff);
		issue(CMD_TMR, 8'h00, 8'h00, 16'h0000);
		issue(CMD_OTE, 8'h07);
		issue(CMD_CLEAR, 8'h00);
		issue(CMD_OTL, 8'h08);
		issue(CMD_OTU, 8'hff);
		issue(CMD_PUSH_OR, 8'h00);
		issue(CMD_XIC, 8'h09);
		issue(CMD_POP_OR, 8'h00);
		issue(CMD_PUSH_CR, 8'h00);
		issue(CMD_POP_CR, 8'h00);
		issue(CMD_TMR, 8'hfe, 8'h00, 16'h0005);
		issue(CMD_SCAN_END, 8'h00);
		issue(CMD_POP_CR, 8'h00);
		issue(CMD_XIC, 8'h00);
		issue(CMD_SCAN_END, 8'h00);
		issue(CMD_READ, 8'hfe);
		issue(CMD_SCAN_START, 8'h00);
		issue(CMD_POP_OR, 8'h00);

		// Random: free flow, sender gaps, receiver stalls, both
		for (int pass = 0; pass < 4; pass++) begin
			case (pass)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 79; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 79; end
				default: begin send_idle_pct = 13; sink_stall_pct = 13; end
			endcase
			pass_end = sent + ITEMS_PER_PASS;
			while (sent < pass_end) begin
				case ($urandom_range(9))
					0: issue(cmd_t'($urandom_range(15)), 8'($urandom), 8'($urandom),
						16'($urandom));
					1: issue(CMD_WRITE, pick_var(), pick_byte());
					2: issue(CMD_READ, pick_var());
					default: run_scan();
				endcase
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain outstanding results, then leave time for stray results
		wait (outcomes_due == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("** ladder_logic_executor_core: PASSED **");
		else
			$display("** ladder_logic_executor_core: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
src/lle_pkg.sv
src/lle_var_store.sv
src/lle_exec.sv
src/ladder_logic_executor_core.sv
tb/ladder_exec_monitor.sv
tb/ladder_logic_executor_core_test.sv
